// ===== design/tcw_pkg.sv =====
// Shared constants, payload types and control structs for the text console writer.
// No dependencies; imported by tcw_ctrl, tcw_datapath and text_console_writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS     = 80;
    localparam int SCROLL_ROWS = 24;
    localparam int CELLS       = COLUMNS * SCROLL_ROWS;

    // Widths
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int POS_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CURSOR_W = 11;
    localparam int REQ_W    = 11;
    localparam int CODE_W   = 9;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Special character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;
    localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h0E4;
    localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h0E5;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

    // Input beat
    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] code;
        logic [REQ_W-1:0]  cell_req;
    } tcw_item_t;

    // Result beat
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   cell_data;
    } tcw_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic copy_step;
        logic zero_step;
        logic finish;
    } tcw_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scroll_now;
        logic sweep_last;
        logic sweep_end;
    } tcw_status_t;

endpackage

// ===== design/tcw_ctrl.sv =====
// Controller state machine of the text console writer: clearing pass, item
// handling, scroll sequencing. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd,
    output logic                busy,
    output logic                done
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_ZERO,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.scroll_now ? ST_COPY : ST_FIN;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.sweep_end)
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (status.sweep_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // Hold state and the busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign done = cmd.finish;

endmodule

// ===== design/tcw_datapath.sv =====
// Datapath of the text console writer: screen cell memory, cursor and column
// registers, sweep counter, attribute register and result data. Depends on tcw_pkg.
module tcw_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcw_pkg::tcw_item_t       item,
    input  tcw_pkg::tcw_cmd_t        cmd,
    input  logic                     cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_data,
    output tcw_pkg::tcw_status_t     status,
    output tcw_pkg::tcw_result_t     result
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    logic [POS_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  sweep_reg, sweep_next;
    logic [ATTR_W-1:0] attr_reg;
    logic              blank_reg, blank_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0] rd_data_reg;

    logic [POS_W-1:0]  pos_inc, pos_dec, pos;
    logic [COL_W-1:0]  col_inc, col_dec, col;
    logic              is_arrow, write_char, scroll;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data;

    // Step the cursor for a put beat
    always_comb
    begin
        pos_inc    = cursor_reg + POS_W'(1);
        pos_dec    = cursor_reg - POS_W'(1);
        col_inc    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
        col_dec    = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
        pos        = cursor_reg;
        col        = col_reg;
        is_arrow   = 1'b0;
        write_char = 1'b0;
        case (item.code)
            CODE_RIGHT:
            begin
                is_arrow = 1'b1;
                if (cursor_reg != POS_W'(CELLS - 1))
                begin
                    pos = pos_inc;
                    col = col_inc;
                end
            end
            CODE_LEFT:
            begin
                is_arrow = 1'b1;
                if (cursor_reg != '0)
                begin
                    pos = pos_dec;
                    col = col_dec;
                end
            end
            CODE_NEWLINE:
            begin
                pos = cursor_reg + POS_W'(COLUMNS) - POS_W'(col_reg);
                col = '0;
            end
            CODE_BACKSPACE:
            begin
                if (cursor_reg != '0)
                begin
                    pos = pos_dec;
                    col = col_dec;
                end
            end
            default:
            begin
                write_char = 1'b1;
                pos        = pos_inc;
                col        = col_inc;
            end
        endcase
        scroll = (item.op == OP_PUT) && !is_arrow && (pos >= POS_W'(CELLS));
    end

    assign status.scroll_now = scroll;
    assign status.sweep_last = (sweep_reg == POS_W'(CELLS - 1));
    assign status.sweep_end  = (sweep_reg == POS_W'(CELLS));

    // Select memory port operations
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(sweep_reg);
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(sweep_reg);
        if (cmd.clear_step || cmd.zero_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.copy_step)
        begin
            // Write back the cell read by the previous copy step, one row up
            wr_en   = (sweep_reg != POS_W'(COLUMNS));
            wr_addr = ADDR_W'(sweep_reg - POS_W'(COLUMNS + 1));
            wr_data = rd_data_reg;
            rd_en   = (sweep_reg != POS_W'(CELLS));
        end
        else if (cmd.accept)
        begin
            wr_en   = (item.op == OP_PUT) && write_char;
            wr_addr = ADDR_W'(cursor_reg);
            wr_data = {attr_reg, item.code[CHAR_W-1:0]};
            rd_en   = (item.op == OP_READ) && (item.cell_req < REQ_W'(CELLS));
            rd_addr = ADDR_W'(item.cell_req);
        end
        else if (cmd.finish)
        begin
            wr_en   = blank_reg;
            wr_addr = ADDR_W'(cursor_reg);
            wr_data = {attr_reg, BLANK_CHAR};
        end
    end

    // Screen cell memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Next values of cursor, sweep and beat flags
    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        sweep_next  = sweep_reg;
        blank_next  = blank_reg;
        rd_ok_next  = rd_ok_reg;
        if (cmd.accept)
        begin
            sweep_next = POS_W'(COLUMNS);
            rd_ok_next = (item.op == OP_READ) && (item.cell_req < REQ_W'(CELLS));
            blank_next = (item.op == OP_PUT) && !is_arrow;
            if (item.op == OP_PUT)
            begin
                cursor_next = scroll ? pos - POS_W'(COLUMNS) : pos;
                col_next    = col;
            end
        end
        else if (cmd.copy_step)
        begin
            sweep_next = status.sweep_end ? cursor_reg : sweep_reg + POS_W'(1);
        end
        else if (cmd.clear_step || cmd.zero_step)
        begin
            sweep_next = sweep_reg + POS_W'(1);
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            col_reg    <= '0;
            sweep_reg  <= '0;
            blank_reg  <= 1'b0;
            rd_ok_reg  <= 1'b0;
            attr_reg   <= ATTR_RESET;
        end
        else
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            sweep_reg  <= sweep_next;
            blank_reg  <= blank_next;
            rd_ok_reg  <= rd_ok_next;
            if (cfg_we)
                attr_reg <= cfg_data;
        end
    end

    // Drive the result beat
    assign result.cursor    = CURSOR_W'(cursor_reg);
    assign result.cell_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// ===== design/text_console_writer.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage: drive item and raise start; the beat is taken at a rising edge where
// start is high and busy is low. item.op selects a put (code) or a cell read
// (cell_req). Every beat yields one result beat: done is high for exactly one
// cycle with result.cursor (cursor after the beat) and result.cell_data
// (read cell, zero for puts and for reads past the last cell).
// Timing: an ordinary put or read shows its result in the cycle after
// acceptance, and busy stays high through that result cycle, so no new beat
// is taken until the result is out; this is set by the single write port of
// the cell memory (character write, then cursor-cell blank).
// A put that reaches the scroll row walks the memory: a row copy that moves
// every cell below the top row up one row, then a zeroing of the tail from
// the cursor to the end, then the result beat.
// Reset: cursor 0, attribute 7, then a clearing pass over all CELLS cells
// zeroes the memory with busy held high; attribute writes are taken anytime.
// The attribute channel (cfg_valid/cfg_ready/cfg_data) is always ready and
// should be written only while no beat is in flight.
// The receiver cannot stall; results are not held.
module text_console_writer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tcw_pkg::tcw_item_t        item,
    output logic                      done,
    output tcw_pkg::tcw_result_t      result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    // Sequence beats
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold cells, cursor and attribute
    tcw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cmd      (cmd),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .result   (result)
    );

endmodule

// ===== tb/tb_text_console_writer.sv =====
// Self-checking testbench for text_console_writer: directed and random put/read beats.
// Depends on tcw_pkg and text_console_writer; predicts every result beat with a shadow screen.
module tb_text_console_writer;

    import tcw_pkg::*;

    typedef enum logic { REQ_BEAT, REQ_ATTR } console_req_kind_t;

    typedef struct {
        console_req_kind_t kind;
        tcw_item_t         beat;
        logic [ATTR_W-1:0] attr;
    } console_req_t;

    localparam int BEATS_PER_PHASE = 150;
    localparam int PHASES          = 5;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    tcw_item_t         item      = '0;
    logic              done;
    tcw_result_t       result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data  = '0;

    // Pending stimulus and expected result beats
    console_req_t request_q[$];
    tcw_result_t  screen_expect_q[$];
    int unsigned  beats_queued;
    int unsigned  mismatch_count;

    // Shadow of the screen state
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                shadow_cursor;
    logic [ATTR_W-1:0] shadow_attr;

    // Driver bookkeeping
    int beats_in_flight;
    int gap_left;
    int burst_left;

    text_console_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock and reset
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    // Apply one beat to the shadow screen and return its result
    function automatic tcw_result_t apply_console_beat(tcw_item_t beat);
        tcw_result_t r;
        int          pos;
        int          i;
        r = '0;
        if (beat.op == OP_READ)
        begin
            if (beat.cell_req < CELLS)
                r.cell_data = shadow_cells[beat.cell_req];
        end
        else
        begin
            pos = shadow_cursor;
            if (pos >= CELLS)
                pos = CELLS - 1;
            if (beat.code == CODE_RIGHT)
            begin
                if (pos + 1 < CELLS)
                    pos++;
            end
            else if (beat.code == CODE_LEFT)
            begin
                if (pos > 0)
                    pos--;
            end
            else
            begin
                if (beat.code == CODE_NEWLINE)
                    pos += COLUMNS - pos % COLUMNS;
                else if (beat.code == CODE_BACKSPACE)
                begin
                    if (pos > 0)
                        pos--;
                end
                else
                begin
                    shadow_cells[pos] = {shadow_attr, beat.code[CHAR_W-1:0]};
                    pos++;
                end
                // Scroll up one row and zero the tail
                if (pos >= CELLS)
                begin
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    pos -= COLUMNS;
                    for (i = pos; i < CELLS; i++)
                        shadow_cells[i] = '0;
                end
                shadow_cells[pos] = {shadow_attr, BLANK_CHAR};
            end
            shadow_cursor = pos;
        end
        r.cursor = CURSOR_W'(shadow_cursor);
        return r;
    endfunction

    task automatic queue_beat(logic op, logic [CODE_W-1:0] code, logic [REQ_W-1:0] req);
        console_req_t r;
        r.kind          = REQ_BEAT;
        r.beat.op       = op;
        r.beat.code     = code;
        r.beat.cell_req = req;
        r.attr          = '0;
        request_q.push_back(r);
        beats_queued++;
    endtask

    task automatic queue_put(logic [CODE_W-1:0] code);
        queue_beat(OP_PUT, code, REQ_W'($urandom_range(0, 2047)));
    endtask

    task automatic queue_read(logic [REQ_W-1:0] req);
        queue_beat(OP_READ, CODE_W'($urandom_range(0, 511)), req);
    endtask

    task automatic queue_attr(logic [ATTR_W-1:0] value);
        console_req_t r;
        r.kind = REQ_ATTR;
        r.beat = '0;
        r.attr = value;
        request_q.push_back(r);
    endtask

    task automatic log_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Driver: present beats in bursts, write the attribute only when idle
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        logic              go;
        tcw_item_t         beat_n;
        logic              cfg_go;
        logic [ATTR_W-1:0] attr_n;
        console_req_t      req;
        if (!rst_n)
        begin
            start           <= 1'b0;
            item            <= '0;
            cfg_valid       <= 1'b0;
            cfg_data        <= '0;
            beats_in_flight = 0;
            gap_left        = 0;
            burst_left      = 1;
        end
        else
        begin
            go     = start;
            beat_n = item;
            cfg_go = cfg_valid;
            attr_n = cfg_data;
            if (start && !busy)
            begin
                go = 1'b0;
                beats_in_flight++;
                burst_left--;
                // Pick the next burst and the gap before it
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(0, 7);
                    end
                end
            end
            if (done)
                beats_in_flight--;
            if (cfg_valid && cfg_ready)
                cfg_go = 1'b0;
            if (!go && !cfg_go && request_q.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_q[0].kind == REQ_BEAT)
                begin
                    req    = request_q.pop_front();
                    go     = 1'b1;
                    beat_n = req.beat;
                end
                else if (beats_in_flight == 0 && !busy)
                begin
                    req    = request_q.pop_front();
                    cfg_go = 1'b1;
                    attr_n = req.attr;
                end
            end
            start     <= go;
            item      <= beat_n;
            cfg_valid <= cfg_go;
            cfg_data  <= attr_n;
        end
    end

    // Monitor: check result beats, predict on every accepted beat
    always @(posedge clk)
    begin : watch_results
        tcw_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (screen_expect_q.size() == 0)
                    log_mismatch("unexpected result beat, cursor", 0, result.cursor);
                else
                begin
                    want = screen_expect_q.pop_front();
                    if (result.cursor !== want.cursor)
                        log_mismatch("cursor", want.cursor, result.cursor);
                    if (result.cell_data !== want.cell_data)
                        log_mismatch("cell_data", want.cell_data, result.cell_data);
                end
            end
            if (start && !busy)
                screen_expect_q.push_back(apply_console_beat(item));
            if (cfg_valid && cfg_ready)
                shadow_attr = cfg_data;
        end
    end

    // Build the stimulus, then wait for the last result beat
    initial
    begin : build_stimulus
        int unsigned phase;
        int unsigned kind;
        int unsigned n;
        int unsigned k;
        int unsigned target;
        int          i;

        for (i = 0; i < CELLS; i++)
            shadow_cells[i] = '0;
        shadow_cursor  = 0;
        shadow_attr    = ATTR_RESET;
        beats_queued   = 0;
        mismatch_count = 0;

        // Directed: cleared screen, reads past the end, clamps at cell 0, wide codes
        queue_read(REQ_W'(0));
        queue_read(REQ_W'(2047));
        queue_read(REQ_W'(CELLS - 1));
        queue_put(CODE_LEFT);
        queue_put(CODE_BACKSPACE);
        queue_put(CODE_W'(8'h41));
        queue_put(CODE_W'(0));
        queue_put(CODE_W'(8'hFF));
        queue_put(CODE_W'(257));
        queue_put(CODE_W'(511));
        queue_put(CODE_RIGHT);
        queue_put(CODE_LEFT);
        queue_put(CODE_BACKSPACE);
        queue_put(CODE_NEWLINE);
        for (i = 0; i < 6; i++)
            queue_read(REQ_W'(i));
        queue_read(REQ_W'(COLUMNS));
        queue_read(REQ_W'(CELLS));
        target = beats_queued;

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: queue_attr(8'h00);
                1: queue_attr(8'hFF);
                default: queue_attr(ATTR_W'($urandom_range(0, 255)));
            endcase

            // Walk to the last cell, clamp the right arrow there, then scroll
            if (phase == 0)
            begin
                for (i = 0; i < SCROLL_ROWS - 1; i++)
                    queue_put(CODE_NEWLINE);
                for (i = 0; i < COLUMNS + 1; i++)
                    queue_put(CODE_RIGHT);
                queue_read(REQ_W'(CELLS - 1));
                queue_put(CODE_W'(8'h7E));
                queue_read(REQ_W'(CELLS - COLUMNS));
                queue_read(REQ_W'(CELLS - COLUMNS - 1));
            end

            target += BEATS_PER_PHASE;
            while (beats_queued < target)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 40)
                begin
                    // Line of text, usually closed by a newline
                    n = $urandom_range(1, 40);
                    for (k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            queue_put(CODE_W'($urandom_range(0, 511)));
                        else
                            queue_put(CODE_W'($urandom_range(32, 126)));
                    end
                    if ($urandom_range(0, 9) < 6)
                        queue_put(CODE_NEWLINE);
                end
                else if (kind < 55)
                begin
                    // Reads, mostly in the lower rows where text lands
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 9))
                            0:       queue_read(REQ_W'($urandom_range(0, 2047)));
                            1, 2, 3: queue_read(REQ_W'($urandom_range(0, CELLS - 1)));
                            default: queue_read(REQ_W'($urandom_range(CELLS - 2 * COLUMNS,
                                                                      CELLS - 1)));
                        endcase
                    end
                end
                else if (kind < 70)
                begin
                    // Arrow runs
                    n = $urandom_range(1, 20);
                    for (k = 0; k < n; k++)
                        queue_put($urandom_range(0, 1) ? CODE_LEFT : CODE_RIGHT);
                end
                else if (kind < 80)
                begin
                    n = $urandom_range(1, 5);
                    for (k = 0; k < n; k++)
                        queue_put(CODE_BACKSPACE);
                end
                else if (kind < 90)
                begin
                    // Noise over all field values
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        queue_beat(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 511)),
                                   REQ_W'($urandom_range(0, 2047)));
                end
                else if (kind < 95)
                begin
                    // Long right run toward the end of the row or the screen
                    n = $urandom_range(60, 100);
                    for (k = 0; k < n; k++)
                        queue_put(CODE_RIGHT);
                    queue_put(CODE_W'($urandom_range(32, 126)));
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        queue_put(CODE_NEWLINE);
                end
            end
        end

        // Drain: all beats taken and every result beat seen
        repeat (10) @(negedge clk);
        while (request_q.size() != 0 || start || cfg_valid || screen_expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer.sv
tb/tb_text_console_writer.sv
